[hw/rtl/ipmap_pkg.sv]
`default_nettype none

package ipmap_pkg;

  localparam int TABLE_SIZE = 2048;
  localparam int KEY_W      = 16;
  localparam int HEAD_W     = 64;
  localparam int TAIL_W     = 48;
  localparam logic [7:0] DOT_CHAR = 8'h2e;

  typedef enum logic [1:0] {
    CMD_INSERT = 2'd0,
    CMD_FIND   = 2'd1,
    CMD_SET    = 2'd2,
    CMD_CLEAR  = 2'd3
  } cmd_t;

  typedef enum logic [2:0] {
    ST_OK       = 3'd0,
    ST_MISS     = 3'd1,
    ST_INSERTED = 3'd2,
    ST_FULL     = 3'd3,
    ST_DOT      = 3'd4,
    ST_CLEARED  = 3'd5
  } status_t;

  typedef enum logic [1:0] {
    S_CLR,
    S_IDLE,
    S_HASH,
    S_CHECK
  } state_t;

  typedef struct packed {
    cmd_t              cmd;
    logic [KEY_W-1:0]  inode;
    logic [KEY_W-1:0]  parent_in;
    logic [HEAD_W-1:0] name_head_in;
    logic [TAIL_W-1:0] name_tail_in;
  } in_item_t;

  typedef struct packed {
    status_t           status;
    logic [KEY_W-1:0]  parent_out;
    logic [HEAD_W-1:0] name_head_out;
    logic [TAIL_W-1:0] name_tail_out;
  } out_item_t;

  // one table slot as stored in the ram
  typedef struct packed {
    logic [KEY_W-1:0]  key;
    logic [KEY_W-1:0]  parent;
    logic [HEAD_W-1:0] head;
    logic [TAIL_W-1:0] tail;
  } slot_t;

  function automatic logic is_dot_name(input logic [HEAD_W-1:0] head);
    logic b0_dot;
    b0_dot = (head[7:0] == DOT_CHAR);
    return b0_dot && ((head[15:8] == 8'h00) ||
                      ((head[15:8] == DOT_CHAR) && (head[23:16] == 8'h00)));
  endfunction

endpackage

`default_nettype wire

[hw/rtl/ipmap_slot_ram.sv]
`default_nettype none

module ipmap_slot_ram #(
  parameter int TableSize = ipmap_pkg::TABLE_SIZE
) (
  input  wire logic                         clk,
  input  wire logic                         we,
  input  wire logic [$clog2(TableSize)-1:0] waddr,
  input  wire ipmap_pkg::slot_t             wdata,
  input  wire logic [$clog2(TableSize)-1:0] raddr,
  output ipmap_pkg::slot_t                  rdata
);
  import ipmap_pkg::*;

  slot_t mem [TableSize];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

[hw/rtl/ipmap_home_calc.sv]
`default_nettype none

// key modulo table size by reciprocal multiplication
module ipmap_home_calc #(
  parameter int TableSize = ipmap_pkg::TABLE_SIZE
) (
  input  wire logic                         clk,
  input  wire logic                         rst_n,
  input  wire logic                         load,
  input  wire logic [ipmap_pkg::KEY_W-1:0]  key,
  output logic                              done,
  output logic [$clog2(TableSize)-1:0]      home
);
  import ipmap_pkg::*;

  localparam int IdxW   = $clog2(TableSize);
  localparam int RecipW = 32;
  localparam int ProdW  = KEY_W + RecipW;
  // floor(2^32 / size) + 1 gives the exact quotient for every 16-bit key
  localparam logic [RecipW-1:0] Recip = RecipW'((64'd1 << 32) / TableSize + 1);

  logic             busy_r;
  logic [KEY_W-1:0] key_r;
  logic [KEY_W-1:0] quot_r;
  logic [ProdW-1:0] prod;
  logic [31:0]      back;
  logic [KEY_W-1:0] rem;

  always_comb begin
    prod = ProdW'(key) * ProdW'(Recip);
    back = 32'(quot_r) * 32'(TableSize);
    rem  = key_r - back[KEY_W-1:0];
    done = busy_r;
    home = rem[IdxW-1:0];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
    end else if (load) begin
      busy_r <= 1'b1;
    end else if (done) begin
      busy_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      key_r  <= key;
      quot_r <= prod[ProdW-1 -: KEY_W];
    end
  end

endmodule

`default_nettype wire

[hw/rtl/inode_parent_hash_map_top.sv]
`default_nettype none

// Inode parent map: open-addressed hash table with linear probing, keyed by
// a 16-bit inode. Each slot keeps key, parent inode and a 14-byte name.
// A command transaction is taken when start is high and busy is low; the
// result comes back as one out_valid strobe of one cycle with out_data.
// The receiver cannot stall, so results are never held.
// Per command:
//   insert, find, set: busy while the home slot is found and probing runs
//   to a slot that holds the key or is empty; the strobe shows in the next
//   cycle, in which a new start is already taken; the home slot is the low
//   key bits for a power-of-two size, else the reciprocal home slot unit's.
//   key zero: strobe in the cycle after the accepting edge, never busy.
//   clear all: one ram write per slot, then the strobe.
// Probing reads the slot ram once per cycle; the read data arrives in the
// next cycle and decides whether to stop or read the next slot.
// Reset starts the same clearing sweep, with busy high and no strobe at
// its end.
module inode_parent_hash_map_top #(
  parameter int TableSize = ipmap_pkg::TABLE_SIZE
) (
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire logic                 start,
  output logic                      busy,
  input  wire ipmap_pkg::in_item_t  in_data,
  output logic                      out_valid,
  output ipmap_pkg::out_item_t      out_data
);
  import ipmap_pkg::*;

  localparam int  IdxW   = $clog2(TableSize);
  localparam int  CntW   = IdxW;
  localparam bit  IsPow2 = ((TableSize & (TableSize - 1)) == 0);
  localparam logic [IdxW-1:0] LastIdx = IdxW'(TableSize - 1);

  state_t          state_r, state_nxt;
  in_item_t        in_r;
  logic [IdxW-1:0] addr_r, addr_nxt;
  logic [CntW-1:0] count_r, count_nxt;
  logic            clr_emit_r, clr_emit_nxt;
  logic            out_valid_r, out_valid_nxt;
  out_item_t       out_r, out_nxt;
  logic            in_load;

  logic            ram_we;
  logic [IdxW-1:0] ram_waddr;
  slot_t           ram_wdata;
  logic [IdxW-1:0] ram_raddr;
  slot_t           ram_rdata;

  logic            hash_load;
  logic            hash_done;
  logic [IdxW-1:0] hash_home;

  logic            slot_empty;
  logic            slot_hit;
  logic            table_full;
  logic [IdxW-1:0] addr_inc;

  ipmap_slot_ram #(.TableSize(TableSize)) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  ipmap_home_calc #(.TableSize(TableSize)) u_home (
    .clk   (clk),
    .rst_n (rst_n),
    .load  (hash_load),
    .key   (in_data.inode),
    .done  (hash_done),
    .home  (hash_home)
  );

  always_comb begin
    slot_empty = (ram_rdata.key == '0);
    slot_hit   = (ram_rdata.key == in_r.inode);
    table_full = (({1'b0, count_r} + 1'b1) >= (CntW + 1)'(TableSize));
    addr_inc   = (addr_r == LastIdx) ? '0 : addr_r + 1'b1;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_CLR;
      addr_r      <= '0;
      count_r     <= '0;
      clr_emit_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      addr_r      <= addr_nxt;
      count_r     <= count_nxt;
      clr_emit_r  <= clr_emit_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_load) begin
      in_r <= in_data;
    end
    out_r <= out_nxt;
  end

  always_comb begin
    state_nxt     = state_r;
    addr_nxt      = addr_r;
    count_nxt     = count_r;
    clr_emit_nxt  = clr_emit_r;
    out_valid_nxt = 1'b0;
    out_nxt       = out_r;
    in_load       = 1'b0;
    hash_load     = 1'b0;
    ram_we        = 1'b0;
    ram_waddr     = addr_r;
    ram_wdata     = '0;
    ram_raddr     = addr_r;

    unique case (state_r)
      S_IDLE: begin
        if (start) begin
          in_load = 1'b1;
          if (in_data.cmd == CMD_CLEAR) begin
            state_nxt    = S_CLR;
            addr_nxt     = '0;
            count_nxt    = '0;
            clr_emit_nxt = 1'b1;
          end else if (in_data.inode == '0) begin
            out_valid_nxt = 1'b1;
            out_nxt       = '0;
            out_nxt.status = ST_MISS;
          end else if (IsPow2) begin
            ram_raddr = in_data.inode[IdxW-1:0];
            addr_nxt  = in_data.inode[IdxW-1:0];
            state_nxt = S_CHECK;
          end else begin
            hash_load = 1'b1;
            state_nxt = S_HASH;
          end
        end
      end

      S_HASH: begin
        if (hash_done) begin
          ram_raddr = hash_home;
          addr_nxt  = hash_home;
          state_nxt = S_CHECK;
        end
      end

      S_CHECK: begin
        out_nxt = '0;
        if (slot_empty) begin
          state_nxt     = S_IDLE;
          out_valid_nxt = 1'b1;
          if (in_r.cmd != CMD_INSERT) begin
            out_nxt.status = ST_MISS;
          end else if (table_full) begin
            out_nxt.status = ST_FULL;
          end else begin
            ram_we        = 1'b1;
            ram_wdata.key = in_r.inode;
            count_nxt     = count_r + 1'b1;
            out_nxt.status = ST_INSERTED;
          end
        end else if (slot_hit) begin
          state_nxt     = S_IDLE;
          out_valid_nxt = 1'b1;
          if (in_r.cmd == CMD_SET) begin
            if (is_dot_name(in_r.name_head_in)) begin
              out_nxt.status = ST_DOT;
            end else begin
              ram_we           = 1'b1;
              ram_wdata.key    = in_r.inode;
              ram_wdata.parent = in_r.parent_in;
              ram_wdata.head   = in_r.name_head_in;
              ram_wdata.tail   = in_r.name_tail_in;
              out_nxt.status        = ST_OK;
              out_nxt.parent_out    = in_r.parent_in;
              out_nxt.name_head_out = in_r.name_head_in;
              out_nxt.name_tail_out = in_r.name_tail_in;
            end
          end else begin
            out_nxt.status        = ST_OK;
            out_nxt.parent_out    = ram_rdata.parent;
            out_nxt.name_head_out = ram_rdata.head;
            out_nxt.name_tail_out = ram_rdata.tail;
          end
        end else begin
          // occupied by another key: move on to the next slot
          ram_raddr = addr_inc;
          addr_nxt  = addr_inc;
        end
      end

      S_CLR: begin
        ram_we = 1'b1;
        if (addr_r == LastIdx) begin
          state_nxt      = S_IDLE;
          clr_emit_nxt   = 1'b0;
          out_valid_nxt  = clr_emit_r;
          out_nxt        = '0;
          out_nxt.status = ST_CLEARED;
        end else begin
          addr_nxt = addr_r + 1'b1;
        end
      end

      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  assign busy      = (state_r != S_IDLE);
  assign out_valid = out_valid_r;
  assign out_data  = out_r;

  a_strobe_when_idle: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> !busy)
    else $error("result strobe while a command is still running");

  a_count_below_size: assert property (@(posedge clk) disable iff (!rst_n)
    ({1'b0, count_r} < (CntW + 1)'(TableSize)))
    else $error("entry count reached the table size");

  a_write_on_probe_end: assert property (@(posedge clk) disable iff (!rst_n)
    (ram_we && state_r == S_CHECK) |-> (slot_empty || slot_hit))
    else $error("slot write on a slot held by another key");

  a_accept_progress: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy) |=> (busy || out_valid))
    else $error("accepted command neither ran nor answered");

  a_clear_writes: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_CLR) |-> (ram_we && ram_wdata == '0))
    else $error("clearing sweep skipped a slot");

endmodule

`default_nettype wire
